[hdl/drs_pkg.sv]
// shared types and constants of the der rsa private key splitter
`default_nettype none
package drs_pkg;

   // fixed field widths
   localparam int KEY_LEN_W = 14;

   // input transaction
   typedef struct packed {
      logic [7:0]           key_byte;
      logic                 first_byte;
      logic [KEY_LEN_W-1:0] key_length;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [3:0] component;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       comp_end;
      logic [2:0] status;
   } rsp_type;

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OLEN,
      PH_OLENX,
      PH_TAG,
      PH_LEN,
      PH_LENX,
      PH_BODY
   } phase_type;

   // status codes
   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_DONE = 3'd1;
   localparam logic [2:0] ST_OTAG = 3'd2;
   localparam logic [2:0] ST_OLEN = 3'd3;
   localparam logic [2:0] ST_ETAG = 3'd4;
   localparam logic [2:0] ST_ELEN = 3'd5;
   localparam logic [2:0] ST_NLEN = 3'd6;

   // der constants
   localparam logic [7:0] SEQ_TAG      = 8'h30;
   localparam logic [7:0] LONG_FORM    = 8'h80;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;
   localparam logic [7:0] TAG_RESET    = 8'h02;
   localparam logic [3:0] LAST_COMP    = 4'd8;

endpackage
`default_nettype wire

[hdl/drs_in_stage.sv]
// input register stage of the der rsa private key splitter
`default_nettype none
module drs_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire drs_pkg::req_type req_payload,
   input  wire logic             advance,
   output logic                  item_valid,
   output drs_pkg::req_type      item
);

   logic             valid_ff;
   drs_pkg::req_type item_ff;

   // hold while the stored transaction cannot move on
   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_payload;
      end
   end

endmodule
`default_nettype wire

[hdl/drs_parser.sv]
// der parsing state and single-step transition logic
`default_nettype none
module drs_parser #(
   parameter int MAX_KEY_BYTES = 8192,
   parameter int MAX_LEN_BYTES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [7:0]       csr_data,
   input  wire logic             step,
   input  wire drs_pkg::req_type item,
   output logic                  res_valid,
   output drs_pkg::rsp_type      res
);

   localparam int SEEN_W = $clog2(MAX_KEY_BYTES + 2);
   localparam int LEN_W  = 8 * MAX_LEN_BYTES;
   localparam int LBL_W  = $clog2(MAX_LEN_BYTES + 1);
   localparam int SUM_W  = ((LEN_W > SEEN_W) ? LEN_W : SEEN_W) + 1;
   localparam int CL_W   = (SEEN_W > drs_pkg::KEY_LEN_W) ? SEEN_W : drs_pkg::KEY_LEN_W;

   drs_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         tag_ff;
   logic [SEEN_W-1:0]  seen_ff, seen_in;
   logic [SEEN_W-1:0]  total_ff, total_in;
   logic [LEN_W-1:0]   accum_ff, accum_in;
   logic [LBL_W-1:0]   lbl_ff, lbl_in;
   logic [3:0]         elem_ff, elem_in;
   logic [SEEN_W-1:0]  content_ff, content_in;
   logic               at_first_ff, at_first_in;

   logic [7:0]         b;
   logic [SEEN_W-1:0]  seen_n;
   logic [CL_W-1:0]    klen_w;
   logic [SEEN_W-1:0]  total_clamp;
   logic [LEN_W-1:0]   accum_shift;
   logic [LEN_W-1:0]   len_sel;
   logic [LBL_W-1:0]   lbl_n;
   logic [SEEN_W-1:0]  cl_n;
   logic               is_outer, is_len, is_lenx, is_body;
   logic               len_over, cnt_over, cnt_many, long_cnt;
   logic               fin, fin_fail, fin_outer, fin_skipver, fin_close, fin_body;
   logic               lf_bad80, lf_many, lf_cntover, lf_start;
   logic               tag_bad, skip, body_last, body_ver_end, body_close, body_emit;
   logic               close, close_last, first_bad, len_zero;
   drs_pkg::phase_type fin_phase;

   assign b = item.key_byte;

   // byte counter saturates one past the largest key
   assign seen_n = (seen_ff <= SEEN_W'(MAX_KEY_BYTES)) ? seen_ff + SEEN_W'(1) : seen_ff;

   // clamp the key length to the largest supported key
   assign klen_w      = CL_W'(item.key_length);
   assign total_clamp = (klen_w > CL_W'(MAX_KEY_BYTES)) ? SEEN_W'(MAX_KEY_BYTES)
                                                         : SEEN_W'(klen_w);

   // phase decode
   assign is_outer = (phase_ff == drs_pkg::PH_OLEN) || (phase_ff == drs_pkg::PH_OLENX);
   assign is_len   = (phase_ff == drs_pkg::PH_OLEN) || (phase_ff == drs_pkg::PH_LEN);
   assign is_lenx  = (phase_ff == drs_pkg::PH_OLENX) || (phase_ff == drs_pkg::PH_LENX);
   assign is_body  = (phase_ff == drs_pkg::PH_BODY);

   // length value of the field being closed
   assign accum_shift = {accum_ff[LEN_W-9:0], b};
   assign len_sel     = is_lenx ? accum_shift : LEN_W'(b);
   assign len_zero    = (len_sel == '0);
   assign lbl_n       = (lbl_ff != '0) ? lbl_ff - LBL_W'(1) : '0;

   // declared length against the bytes left in the key
   assign len_over = (SUM_W'(len_sel) + SUM_W'(seen_n)) > SUM_W'(total_ff);
   assign cnt_over = (SUM_W'(b[6:0]) + SUM_W'(seen_n)) > SUM_W'(total_ff);
   assign cnt_many = b[6:0] > 7'(MAX_LEN_BYTES);
   assign long_cnt = b[7] && (b[6:0] != 7'd0);

   // length field completion
   assign fin         = (is_len && !b[7]) || (is_lenx && (lbl_n == '0));
   assign fin_fail    = fin && len_over;
   assign fin_outer   = fin && !len_over && is_outer;
   assign fin_skipver = fin && !len_over && !is_outer && len_zero && (elem_ff == 4'd0);
   assign fin_close   = fin && !len_over && !is_outer && len_zero && (elem_ff != 4'd0);
   assign fin_body    = fin && !len_over && !is_outer && !len_zero;

   // first length byte in long form
   assign lf_bad80   = is_len && (b == drs_pkg::LONG_FORM);
   assign lf_many    = is_len && long_cnt && cnt_many;
   assign lf_cntover = is_len && long_cnt && !cnt_many && cnt_over;
   assign lf_start   = is_len && long_cnt && !cnt_many && !cnt_over;

   assign tag_bad = (phase_ff == drs_pkg::PH_TAG) && (b != tag_ff);

   // content bytes
   assign skip         = at_first_ff && (b == drs_pkg::ZERO_BYTE);
   assign cl_n         = (content_ff != '0) ? content_ff - SEEN_W'(1) : '0;
   assign body_last    = (cl_n == '0);
   assign body_ver_end = is_body && (elem_ff == 4'd0) && body_last;
   assign body_close   = is_body && (elem_ff != 4'd0) && body_last;
   assign body_emit    = is_body && (elem_ff != 4'd0) && !body_last && !skip;

   assign close      = fin_close || body_close;
   assign close_last = (elem_ff >= drs_pkg::LAST_COMP);
   assign first_bad  = item.first_byte && (b != drs_pkg::SEQ_TAG);

   // phase after a completed length field
   always_comb begin
      if (fin_fail) begin
         fin_phase = drs_pkg::PH_IDLE;
      end else if (fin_body) begin
         fin_phase = drs_pkg::PH_BODY;
      end else if (fin_close && close_last) begin
         fin_phase = drs_pkg::PH_IDLE;
      end else begin
         fin_phase = drs_pkg::PH_TAG;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (item.first_byte) begin
            phase_in = first_bad ? drs_pkg::PH_IDLE : drs_pkg::PH_OLEN;
         end else begin
            case (phase_ff)
               drs_pkg::PH_IDLE: begin
                  phase_in = drs_pkg::PH_IDLE;
               end
               drs_pkg::PH_OLEN, drs_pkg::PH_LEN: begin
                  if (fin) begin
                     phase_in = fin_phase;
                  end else if (lf_bad80 || lf_many || lf_cntover) begin
                     phase_in = drs_pkg::PH_IDLE;
                  end else begin
                     phase_in = is_outer ? drs_pkg::PH_OLENX : drs_pkg::PH_LENX;
                  end
               end
               drs_pkg::PH_OLENX, drs_pkg::PH_LENX: begin
                  phase_in = fin ? fin_phase : phase_ff;
               end
               drs_pkg::PH_TAG: begin
                  phase_in = tag_bad ? drs_pkg::PH_IDLE : drs_pkg::PH_LEN;
               end
               drs_pkg::PH_BODY: begin
                  if (body_ver_end) begin
                     phase_in = drs_pkg::PH_TAG;
                  end else if (body_close) begin
                     phase_in = close_last ? drs_pkg::PH_IDLE : drs_pkg::PH_TAG;
                  end else begin
                     phase_in = drs_pkg::PH_BODY;
                  end
               end
               default: begin
                  phase_in = drs_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   // counters, length accumulation and result
   always_comb begin
      seen_in     = seen_ff;
      total_in    = total_ff;
      accum_in    = accum_ff;
      lbl_in      = lbl_ff;
      elem_in     = elem_ff;
      content_in  = content_ff;
      at_first_in = at_first_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (step && item.first_byte) begin
         total_in    = total_clamp;
         seen_in     = SEEN_W'(1);
         elem_in     = 4'd0;
         accum_in    = '0;
         lbl_in      = '0;
         content_in  = '0;
         at_first_in = 1'b0;
         if (first_bad) begin
            res_valid  = 1'b1;
            res.status = drs_pkg::ST_OTAG;
         end
      end else if (step && (phase_ff != drs_pkg::PH_IDLE)) begin
         seen_in = seen_n;
         if (lf_start) begin
            accum_in = '0;
            lbl_in   = LBL_W'(b[6:0]);
         end else if (is_lenx) begin
            accum_in = accum_shift;
            lbl_in   = lbl_n;
         end
         if (fin_outer) begin
            elem_in = 4'd0;
         end else if (fin_skipver || body_ver_end) begin
            elem_in = 4'd1;
         end else if (close && !close_last) begin
            elem_in = elem_ff + 4'd1;
         end
         if (fin_body) begin
            content_in  = SEEN_W'(len_sel);
            at_first_in = 1'b1;
         end else if (is_body) begin
            content_in  = cl_n;
            at_first_in = 1'b0;
         end
         // error results
         if (fin_fail || lf_bad80 || lf_cntover) begin
            res_valid  = 1'b1;
            res.status = is_outer ? drs_pkg::ST_OLEN : drs_pkg::ST_ELEN;
         end else if (lf_many) begin
            res_valid  = 1'b1;
            res.status = drs_pkg::ST_NLEN;
         end else if (tag_bad) begin
            res_valid  = 1'b1;
            res.status = drs_pkg::ST_ETAG;
         end else if (close) begin
            res_valid      = 1'b1;
            res.component  = elem_ff;
            res.byte_valid = body_close && !skip;
            res.data_byte  = (body_close && !skip) ? b : drs_pkg::ZERO_BYTE;
            res.comp_end   = 1'b1;
            res.status     = close_last ? drs_pkg::ST_DONE : drs_pkg::ST_OK;
         end else if (body_emit) begin
            res_valid      = 1'b1;
            res.component  = elem_ff;
            res.byte_valid = 1'b1;
            res.data_byte  = b;
            res.status     = drs_pkg::ST_OK;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= drs_pkg::PH_IDLE;
         seen_ff     <= '0;
         total_ff    <= '0;
         accum_ff    <= '0;
         lbl_ff      <= '0;
         elem_ff     <= 4'd0;
         content_ff  <= '0;
         at_first_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         seen_ff     <= seen_in;
         total_ff    <= total_in;
         accum_ff    <= accum_in;
         lbl_ff      <= lbl_in;
         elem_ff     <= elem_in;
         content_ff  <= content_in;
         at_first_ff <= at_first_in;
      end
   end

   // element tag register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= drs_pkg::TAG_RESET;
      end else if (csr_valid) begin
         tag_ff <= csr_data;
      end
   end

   // an error result leaves the parser idle
   a_err_idles: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status != drs_pkg::ST_OK) && (res.status != drs_pkg::ST_DONE)
      |=> (phase_ff == drs_pkg::PH_IDLE))
      else $error("parser not idle after error result");

   // the coefficient close ends the key
   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status == drs_pkg::ST_DONE)
      |-> (res.component == drs_pkg::LAST_COMP) && (phase_in == drs_pkg::PH_IDLE))
      else $error("key done outside the last component");

   // body phase always has content left to read
   a_body_content: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == drs_pkg::PH_BODY) |-> (content_ff != '0))
      else $error("body phase with no content left");

   // byte counter never passes its saturation point
   a_seen_sat: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(MAX_KEY_BYTES + 1))
      else $error("byte counter overran");

endmodule
`default_nettype wire

[hdl/drs_out_stage.sv]
// result register stage of the der rsa private key splitter
`default_nettype none
module drs_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             res_valid,
   input  wire drs_pkg::rsp_type res,
   output logic                  free,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output drs_pkg::rsp_type      rsp_payload
);

   logic             valid_ff;
   drs_pkg::rsp_type data_ff;

   // register can take a new transaction when empty or draining
   assign free        = !valid_ff || !rsp_stall;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (free && res_valid) begin
         data_ff <= res;
      end
   end

endmodule
`default_nettype wire

[hdl/der_rsa_private_key_splitter.sv]
// Top level of the der rsa private key splitter.
// Each accepted key byte is held in the input register, its result in the result register.
// Throughput: one key byte per cycle unless rsp_stall holds the result register; each
// byte takes one pass through the parser step between the input and result registers.
// Reset (synchronous, active high): parser idle, counters cleared, element tag 0x02.
`default_nettype none
module der_rsa_private_key_splitter #(
   parameter int MAX_KEY_BYTES = 8192,
   parameter int MAX_LEN_BYTES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire drs_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output drs_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_data
);

   logic             item_valid;
   drs_pkg::req_type item;
   logic             free;
   logic             step;
   logic             res_valid;
   drs_pkg::rsp_type res;

   // register writes always complete at once
   assign csr_ready = 1'b1;

   // parser advances when the result register can take its output
   assign step = item_valid && free;

   drs_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (free),
      .item_valid  (item_valid),
      .item        (item)
   );

   drs_parser #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .MAX_LEN_BYTES (MAX_LEN_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   drs_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res         (res),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

[dv/tb_top.sv]
// testbench for the der rsa private key splitter: random keys, in-order byte checking
`timescale 1ns / 100ps
module tb_top;

   localparam int MAX_KEY_BYTES = 8192;
   localparam int MAX_LEN_BYTES = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 3000;
   localparam int BATCH_ITEMS   = 200;

   typedef logic [7:0] octet_q_type[$];

   // ways a generated key is broken
   typedef enum int {
      FLAW_NONE,
      FLAW_INDEF_LEN,
      FLAW_LONG_COUNT,
      FLAW_SHORT_KEY,
      FLAW_RANDOM_BYTE,
      FLAW_TRUNCATE
   } flaw_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   drs_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   drs_pkg::rsp_type rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_data = 8'h00;

   // stimulus and scoreboard storage
   drs_pkg::req_type key_bytes_queued[$];
   drs_pkg::rsp_type results_due[$];
   int      bytes_total = 0;
   int      bytes_accepted = 0;
   int      results_checked = 0;
   int      mismatches = 0;
   logic    req_fire = 1'b0;

   // idling control
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // predicted parser state
   drs_pkg::phase_type ph = drs_pkg::PH_IDLE;
   int unsigned seen = 0;
   int unsigned total = 0;
   logic [31:0] accum = '0;
   int unsigned lbytes_left = 0;
   logic [3:0]  elem_idx = '0;
   int unsigned body_left = 0;
   bit          first_content = 1'b0;
   logic [7:0]  tag_reg = drs_pkg::TAG_RESET;

   der_rsa_private_key_splitter #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES),
      .MAX_LEN_BYTES(MAX_LEN_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // error result, parser goes idle
   function automatic bit error_out(input logic [2:0] st, output drs_pkg::rsp_type o);
      o = '0;
      o.status = st;
      ph = drs_pkg::PH_IDLE;
      return 1'b1;
   endfunction

   // last result of a component, then next element or key done
   function automatic bit close_component(input logic [7:0] d, input bit v,
                                          output drs_pkg::rsp_type o);
      o = '0;
      o.component = elem_idx;
      o.data_byte = d;
      o.byte_valid = v;
      o.comp_end = 1'b1;
      if (elem_idx >= drs_pkg::LAST_COMP) begin
         ph = drs_pkg::PH_IDLE;
         o.status = drs_pkg::ST_DONE;
      end else begin
         elem_idx = elem_idx + 4'd1;
         ph = drs_pkg::PH_TAG;
         o.status = drs_pkg::ST_OK;
      end
      return 1'b1;
   endfunction

   // declared length is complete: check it and set up the content
   function automatic bit end_length(input logic [31:0] len, input longint rem,
                                     input bit outer, output drs_pkg::rsp_type o);
      o = '0;
      if (longint'({32'd0, len}) > rem)
         return error_out(outer ? drs_pkg::ST_OLEN : drs_pkg::ST_ELEN, o);
      if (outer) begin
         elem_idx = '0;
         ph = drs_pkg::PH_TAG;
         return 1'b0;
      end
      if (len == 0) begin
         if (elem_idx == 0) begin
            elem_idx = 4'd1;
            ph = drs_pkg::PH_TAG;
            return 1'b0;
         end
         return close_component(drs_pkg::ZERO_BYTE, 1'b0, o);
      end
      body_left = len;
      first_content = 1'b1;
      ph = drs_pkg::PH_BODY;
      return 1'b0;
   endfunction

   // one key byte through the parser; returns 1 when it gives a result
   function automatic bit parse_byte(input drs_pkg::req_type r, output drs_pkg::rsp_type o);
      logic [7:0]  b;
      longint      rem;
      bit          outer;
      bit          skip;
      int unsigned cnt;
      b = r.key_byte;
      o = '0;
      if (r.first_byte) begin
         total = (r.key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : r.key_length;
         seen = 1;
         elem_idx = '0;
         accum = '0;
         lbytes_left = 0;
         body_left = 0;
         first_content = 1'b0;
         if (b != drs_pkg::SEQ_TAG) return error_out(drs_pkg::ST_OTAG, o);
         ph = drs_pkg::PH_OLEN;
         return 1'b0;
      end
      if (ph == drs_pkg::PH_IDLE) return 1'b0;
      if (seen <= MAX_KEY_BYTES) seen++;
      rem = longint'(total) - longint'(seen);
      outer = (ph == drs_pkg::PH_OLEN || ph == drs_pkg::PH_OLENX);
      case (ph)
         drs_pkg::PH_OLEN, drs_pkg::PH_LEN: begin
            if (b < drs_pkg::LONG_FORM) return end_length({24'd0, b}, rem, outer, o);
            if (b == drs_pkg::LONG_FORM)
               return error_out(outer ? drs_pkg::ST_OLEN : drs_pkg::ST_ELEN, o);
            cnt = b - drs_pkg::LONG_FORM;
            if (cnt > MAX_LEN_BYTES) return error_out(drs_pkg::ST_NLEN, o);
            if (longint'(cnt) > rem)
               return error_out(outer ? drs_pkg::ST_OLEN : drs_pkg::ST_ELEN, o);
            accum = '0;
            lbytes_left = cnt;
            ph = outer ? drs_pkg::PH_OLENX : drs_pkg::PH_LENX;
            return 1'b0;
         end
         drs_pkg::PH_OLENX, drs_pkg::PH_LENX: begin
            accum = {accum[23:0], b};
            if (lbytes_left > 0) lbytes_left--;
            if (lbytes_left == 0) return end_length(accum, rem, outer, o);
            return 1'b0;
         end
         drs_pkg::PH_TAG: begin
            if (b != tag_reg) return error_out(drs_pkg::ST_ETAG, o);
            ph = drs_pkg::PH_LEN;
            return 1'b0;
         end
         drs_pkg::PH_BODY: begin
            skip = first_content && (b == drs_pkg::ZERO_BYTE);
            first_content = 1'b0;
            if (body_left > 0) body_left--;
            // version content is swallowed
            if (elem_idx == 0) begin
               if (body_left == 0) begin
                  elem_idx = 4'd1;
                  ph = drs_pkg::PH_TAG;
               end
               return 1'b0;
            end
            if (body_left == 0) begin
               if (skip) return close_component(drs_pkg::ZERO_BYTE, 1'b0, o);
               return close_component(b, 1'b1, o);
            end
            if (skip) return 1'b0;
            o.component = elem_idx;
            o.data_byte = b;
            o.byte_valid = 1'b1;
            o.status = drs_pkg::ST_OK;
            return 1'b1;
         end
         default: begin
            ph = drs_pkg::PH_IDLE;
            return 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("mismatch: %s at result %0d, got %0h expected %0h",
               field, results_checked, got, want);
   endtask

   // driver: next key byte offered at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (key_bytes_queued.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= key_bytes_queued.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor: check results, then predict for the accepted key byte
   always @(posedge clock) begin
      drs_pkg::rsp_type got;
      drs_pkg::rsp_type want;
      drs_pkg::rsp_type predicted;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_payload;
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing pending", int'(got), 0);
         end else begin
            want = results_due.pop_front();
            if (got.component !== want.component)
               report_mismatch("component", int'(got.component), int'(want.component));
            if (got.data_byte !== want.data_byte)
               report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
            if (got.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
            if (got.comp_end !== want.comp_end)
               report_mismatch("comp_end", int'(got.comp_end), int'(want.comp_end));
            if (got.status !== want.status)
               report_mismatch("status", int'(got.status), int'(want.status));
            results_checked++;
         end
      end
      if (!reset && req_valid && !req_stall) begin
         bytes_accepted++;
         if (parse_byte(req_payload, predicted)) results_due.push_back(predicted);
      end
   end

   // watchdog on cycles with no transaction on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d results pending", results_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] b, input bit first, input logic [13:0] klen);
      drs_pkg::req_type item;
      item.key_byte = b;
      item.first_byte = first;
      item.key_length = klen;
      key_bytes_queued.push_back(item);
      bytes_total++;
   endtask

   task automatic queue_bytes(input octet_q_type bytes, input logic [13:0] klen);
      push_item(bytes[0], 1'b1, klen);
      for (int i = 1; i < bytes.size(); i++) push_item(bytes[i], 1'b0, 14'($urandom));
   endtask

   // short or long form length, sometimes padded with leading zero bytes
   task automatic put_length(ref octet_q_type q, input int unsigned len);
      int n;
      if (len < 128 && $urandom_range(0, 3) != 0) begin
         q.push_back(8'(len));
         return;
      end
      n = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(n, MAX_LEN_BYTES);
      q.push_back(drs_pkg::LONG_FORM | 8'(n));
      for (int i = n - 1; i >= 0; i--) q.push_back(8'(len >> (8 * i)));
   endtask

   // one key image with random components, optionally broken
   task automatic queue_key(input logic [7:0] etag, input flaw_type flaw);
      octet_q_type body;
      octet_q_type key;
      int unsigned clen;
      int unsigned klen;
      int          bad_elem;
      int          r;
      bad_elem = $urandom_range(0, 8);
      for (int e = 0; e < 9; e++) begin
         body.push_back(etag);
         if (e == bad_elem && flaw == FLAW_INDEF_LEN) begin
            body.push_back(drs_pkg::LONG_FORM);
            break;
         end
         if (e == bad_elem && flaw == FLAW_LONG_COUNT) begin
            body.push_back(drs_pkg::LONG_FORM
                           | 8'($urandom_range(MAX_LEN_BYTES + 1, 127)));
            break;
         end
         r = $urandom_range(0, 99);
         if (e == 0) clen = $urandom_range(0, 2);
         else if (r < 15) clen = 0;
         else if (r < 90) clen = $urandom_range(1, 4);
         else if (r < 99) clen = $urandom_range(5, 20);
         else clen = $urandom_range(128, 260);
         put_length(body, clen);
         for (int i = 0; i < clen; i++)
            body.push_back((i == 0 && $urandom_range(0, 2) == 0) ? drs_pkg::ZERO_BYTE
                                                                 : 8'($urandom));
      end
      key.push_back(drs_pkg::SEQ_TAG);
      put_length(key, body.size());
      key = {key, body};
      klen = key.size();
      case (flaw)
         FLAW_NONE: begin
            r = $urandom_range(0, 99);
            if (r < 8) repeat ($urandom_range(1, 6)) key.push_back(8'($urandom));
            else if (r < 12) klen = $urandom_range(MAX_KEY_BYTES, 16383);
            else if (r < 15) klen = 0;
         end
         FLAW_SHORT_KEY: klen = klen - $urandom_range(1, 3);
         FLAW_RANDOM_BYTE: key[$urandom_range(0, key.size() - 1)] = 8'($urandom);
         FLAW_TRUNCATE: repeat ($urandom_range(1, key.size() - 1)) void'(key.pop_back());
         default: ;
      endcase
      queue_bytes(key, 14'(klen));
   endtask

   // mix of clean keys, broken keys and stray bytes
   task automatic queue_traffic(input logic [7:0] etag, input int n);
      int start;
      int r;
      start = bytes_total;
      while (bytes_total - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 65)
            queue_key(etag, FLAW_NONE);
         else if (r < 90)
            queue_key(etag, flaw_type'($urandom_range(FLAW_INDEF_LEN, FLAW_TRUNCATE)));
         else
            repeat ($urandom_range(1, 8))
               push_item(8'($urandom), $urandom_range(0, 3) == 0, 14'($urandom));
      end
   endtask

   task automatic write_tag(input logic [7:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      tag_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all bytes taken, all results seen, pipeline settled
   task automatic wait_drained;
      do @(negedge clock); while (bytes_accepted != bytes_total || results_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_tag(drs_pkg::TAG_RESET);
      send_idle_pct = 17;
      recv_idle_pct = 53;
      // small complete key: empty, zero-only and zero-led components, clamped key length
      queue_bytes('{8'h30, 8'h81, 8'h15, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00,
                    8'h02, 8'h02, 8'h00, 8'hFF, 8'h02, 8'h00, 8'h02, 8'h00,
                    8'h02, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00}, 14'd16383);
      // bad outer tag, indefinite length, too many length bytes
      queue_bytes('{8'hFF}, 14'd0);
      queue_bytes('{8'h30, 8'h80}, 14'd100);
      queue_bytes('{8'h30, 8'h85}, 14'd100);
      // length byte count beyond the key, then bad element tag
      queue_bytes('{8'h30, 8'h81}, 14'd2);
      queue_bytes('{8'h30, 8'h00, 8'hFF}, 14'd3);
      wait_drained();

      // sender idles lightly, receiver heavily, with one long hold-off
      queue_traffic(drs_pkg::TAG_RESET, BATCH_ITEMS);
      hold_token++;
      wait_drained();

      write_tag(8'hFF);
      send_idle_pct = 53;
      recv_idle_pct = 17;
      queue_traffic(8'hFF, BATCH_ITEMS);
      wait_drained();

      write_tag(8'h00);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_traffic(8'h00, BATCH_ITEMS);
      wait_drained();

      write_tag(8'($urandom_range(1, 254)));
      queue_traffic(tag_reg, BATCH_ITEMS);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
